/* hw/rtl/rgpq_pkg.sv */
package rgpq_pkg;

  // Widest run-count field that still yields a value; wider fields read as zero.
  localparam int unsigned MaxCountBits = 16;

  typedef enum logic [1:0] {
    CLS_BACKGROUND  = 2'd0,
    CLS_FOREGROUND  = 2'd1,
    CLS_TRANSPARENT = 2'd2
  } pixel_class_e;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    REG_ZERO_RUN_BITS    = 3'd0,
    REG_ONE_RUN_BITS     = 3'd1,
    REG_GLYPH_WIDTH      = 3'd2,
    REG_GLYPH_HEIGHT     = 3'd3,
    REG_START_BIT        = 3'd4,
    REG_FOREGROUND_COLOR = 3'd5,
    REG_BACKGROUND_COLOR = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_START,
    WS_FIELD,
    WS_FETCH,
    WS_WAIT,
    WS_RUN,
    WS_DONE
  } walk_state_e;

  typedef enum logic [1:0] {
    PH_ZERO,
    PH_ONE,
    PH_REP
  } walk_phase_e;

  typedef struct packed {
    logic [4:0]         zero_run_bits;
    logic [4:0]         one_run_bits;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic [2:0]         start_bit;
    logic signed [31:0] foreground_color;
    logic signed [31:0] background_color;
  } cfg_t;

  localparam logic [4:0]  RstZeroRunBits = 5'd4;
  localparam logic [4:0]  RstOneRunBits  = 5'd4;
  localparam logic [7:0]  RstGlyphWidth  = 8'd8;
  localparam logic [7:0]  RstGlyphHeight = 8'd8;
  localparam logic [2:0]  RstStartBit    = 3'd0;
  localparam logic [31:0] RstColor       = 32'd0;

endpackage

/* hw/rtl/rle_glyph_pixel_query.sv */
// Run-length coded glyph store with pixel lookup. Write words (tuser = 0) put one
// bitmap byte into a BITMAP_BYTES-deep single-port-read RAM in the cycle they are
// accepted and return nothing. Query words (tuser = 1) walk the coded stream from
// start_bit of byte 0, least significant bit first: a zero-run count, a one-run
// count and a unary repeat field per record, and return one result word holding
// the pixel class (background, foreground, transparent) and its configured color.
// Pixels outside the box, a stream that runs off the end of the store, or a walk
// that covers the whole box first all answer transparent with color zero.
// One query is handled at a time. A query is set up first, then reads every count
// and repeat field one stream bit at a time and closes each count field, fetches
// each bitmap byte from the RAM when the buffer runs empty (see the empty buffer,
// issue the read, capture the data), makes one pass per repeat of a record, and
// loads the result register; input is taken again the cycle after. The field
// reader is bit-serial and the RAM read is registered. A finished result sits in
// an output register, so the next word is taken while the previous result still
// waits. Write the configuration registers only while no query is in flight.
module rle_glyph_pixel_query #(
  parameter int unsigned BITMAP_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // byte_index[7:0], byte_value[15:8], pixel_x[23:16],
                                     // pixel_y[31:24]
  input  logic        s_axis_tuser,  // mode[0]
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // pixel_class[1:0], pixel_color[33:2], zero pad[39:34]
);

  localparam int unsigned AW = $clog2(BITMAP_BYTES);

  rgpq_pkg::cfg_t  cfg;
  logic            accept;
  logic            walk_idle;
  logic            mem_we;
  logic [AW+7:0]   wr_idx_wide;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rd_data;
  logic [1:0]      out_class;
  logic [31:0]     out_color;

  assign s_axis_tready = walk_idle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // drop bitmap writes that land beyond the store
  assign wr_idx_wide = {{AW{1'b0}}, s_axis_tdata[7:0]};
  assign mem_we      = accept && (s_axis_tuser == rgpq_pkg::MODE_WRITE) &&
                       (32'(s_axis_tdata[7:0]) < BITMAP_BYTES);

  rgpq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rgpq_ram #(
    .WIDTH (8),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_idx_wide[AW-1:0]),
    .wdata_i (s_axis_tdata[15:8]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  rgpq_walker #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (accept && (s_axis_tuser == rgpq_pkg::MODE_QUERY)),
    .pixel_x_i   (s_axis_tdata[23:16]),
    .pixel_y_i   (s_axis_tdata[31:24]),
    .idle_o      (walk_idle),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_class_o (out_class),
    .out_color_o (out_color)
  );

  assign m_axis_tdata = {6'b0, out_color, out_class};

endmodule

/* hw/rtl/rgpq_ram.sv */
module rgpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/rgpq_cfg.sv */
module rgpq_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output rgpq_pkg::cfg_t       cfg_o
);

  rgpq_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (rgpq_pkg::cfg_reg_e'(cfg_idx_i))
        rgpq_pkg::REG_ZERO_RUN_BITS:    cfg_d.zero_run_bits    = cfg_data_i[4:0];
        rgpq_pkg::REG_ONE_RUN_BITS:     cfg_d.one_run_bits     = cfg_data_i[4:0];
        rgpq_pkg::REG_GLYPH_WIDTH:      cfg_d.glyph_width      = cfg_data_i[7:0];
        rgpq_pkg::REG_GLYPH_HEIGHT:     cfg_d.glyph_height     = cfg_data_i[7:0];
        rgpq_pkg::REG_START_BIT:        cfg_d.start_bit        = cfg_data_i[2:0];
        rgpq_pkg::REG_FOREGROUND_COLOR: cfg_d.foreground_color = cfg_data_i;
        rgpq_pkg::REG_BACKGROUND_COLOR: cfg_d.background_color = cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_run_bits    <= rgpq_pkg::RstZeroRunBits;
      cfg_q.one_run_bits     <= rgpq_pkg::RstOneRunBits;
      cfg_q.glyph_width      <= rgpq_pkg::RstGlyphWidth;
      cfg_q.glyph_height     <= rgpq_pkg::RstGlyphHeight;
      cfg_q.start_bit        <= rgpq_pkg::RstStartBit;
      cfg_q.foreground_color <= rgpq_pkg::RstColor;
      cfg_q.background_color <= rgpq_pkg::RstColor;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/rgpq_walker.sv */
module rgpq_walker #(
  parameter int unsigned BITMAP_BYTES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rgpq_pkg::cfg_t                  cfg_i,
  input  logic                            start_i,
  input  logic [7:0]                      pixel_x_i,
  input  logic [7:0]                      pixel_y_i,
  output logic                            idle_o,
  output logic                            rd_en_o,
  output logic [$clog2(BITMAP_BYTES)-1:0] rd_addr_o,
  input  logic [7:0]                      rd_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      out_class_o,
  output logic [31:0]                     out_color_o
);

  localparam int unsigned AW    = $clog2(BITMAP_BYTES);
  localparam int unsigned POS_W = $clog2(BITMAP_BYTES * 8 + 1);
  localparam logic [POS_W:0] TotalBits = (POS_W + 1)'(BITMAP_BYTES * 8);

  rgpq_pkg::walk_state_e  state_q, state_d;
  rgpq_pkg::walk_phase_e  phase_q, phase_d;
  rgpq_pkg::pixel_class_e res_q, res_d;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] ones_q, ones_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [15:0]      val_q, val_d;
  logic [15:0]      nz_q, nz_d;
  logic [15:0]      no_q, no_d;
  logic [15:0]      p_q, p_d;
  logic [15:0]      tgt_q, tgt_d;
  logic [15:0]      area_q, area_d;
  logic [7:0]       x_q, x_d;
  logic [7:0]       y_q, y_d;
  logic [7:0]       byte_q, byte_d;
  logic             buf_ok_q, buf_ok_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_class_q, out_class_d;
  logic [31:0]      out_color_q, out_color_d;

  logic [4:0]       len;
  logic [POS_W:0]   pos_end;
  logic             cur_bit;
  logic [17:0]      sum_zero;
  logic [17:0]      sum_one;

  assign len      = (phase_q == rgpq_pkg::PH_ZERO) ? cfg_i.zero_run_bits : cfg_i.one_run_bits;
  assign pos_end  = {1'b0, pos_q} + (POS_W + 1)'(len);
  assign cur_bit  = byte_q[pos_q[2:0]];
  assign sum_zero = 18'(p_q) + 18'(nz_q);
  assign sum_one  = sum_zero + 18'(no_q);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    res_d       = res_q;
    pos_d       = pos_q;
    ones_d      = ones_q;
    cnt_d       = cnt_q;
    val_d       = val_q;
    nz_d        = nz_q;
    no_d        = no_q;
    p_d         = p_q;
    tgt_d       = tgt_q;
    area_d      = area_q;
    x_d         = x_q;
    y_d         = y_q;
    byte_d      = byte_q;
    buf_ok_d    = buf_ok_q;
    out_valid_d = out_valid_q;
    out_class_d = out_class_q;
    out_color_d = out_color_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = pos_q[AW+2:3];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rgpq_pkg::WS_IDLE: begin
        if (start_i) begin
          x_d     = pixel_x_i;
          y_d     = pixel_y_i;
          state_d = rgpq_pkg::WS_START;
        end
      end

      rgpq_pkg::WS_START: begin
        tgt_d    = 16'(y_q) * 16'(cfg_i.glyph_width) + 16'(x_q);
        area_d   = 16'(cfg_i.glyph_width) * 16'(cfg_i.glyph_height);
        pos_d    = POS_W'(cfg_i.start_bit);
        phase_d  = rgpq_pkg::PH_ZERO;
        cnt_d    = '0;
        val_d    = '0;
        p_d      = '0;
        buf_ok_d = 1'b0;
        if (cfg_i.glyph_width == 8'd0 || cfg_i.glyph_height == 8'd0 ||
            x_q >= cfg_i.glyph_width || y_q >= cfg_i.glyph_height) begin
          res_d   = rgpq_pkg::CLS_TRANSPARENT;
          state_d = rgpq_pkg::WS_DONE;
        end else begin
          state_d = rgpq_pkg::WS_FIELD;
        end
      end

      rgpq_pkg::WS_FIELD: begin
        if (phase_q == rgpq_pkg::PH_REP) begin
          // unary repeat field: ones closed by a zero
          if ({1'b0, pos_q} >= TotalBits) begin
            res_d   = rgpq_pkg::CLS_TRANSPARENT;
            state_d = rgpq_pkg::WS_DONE;
          end else if (!buf_ok_q) begin
            state_d = rgpq_pkg::WS_FETCH;
          end else begin
            pos_d = pos_q + 1'b1;
            if (pos_q[2:0] == 3'b111) begin
              buf_ok_d = 1'b0;
            end
            if (cur_bit) begin
              ones_d = ones_q + 1'b1;
            end else begin
              state_d = rgpq_pkg::WS_RUN;
            end
          end
        end else begin
          // run-count field, checked against the store end before its first bit
          if (cnt_q == 5'd0 && pos_end > TotalBits) begin
            res_d   = rgpq_pkg::CLS_TRANSPARENT;
            state_d = rgpq_pkg::WS_DONE;
          end else if (cnt_q == len) begin
            if (phase_q == rgpq_pkg::PH_ZERO) begin
              nz_d    = val_q;
              phase_d = rgpq_pkg::PH_ONE;
            end else begin
              no_d    = val_q;
              ones_d  = '0;
              phase_d = rgpq_pkg::PH_REP;
            end
            cnt_d = '0;
            val_d = '0;
          end else if (!buf_ok_q) begin
            state_d = rgpq_pkg::WS_FETCH;
          end else begin
            if (len <= 5'(rgpq_pkg::MaxCountBits)) begin
              val_d[cnt_q[3:0]] = cur_bit;
            end
            cnt_d = cnt_q + 1'b1;
            pos_d = pos_q + 1'b1;
            if (pos_q[2:0] == 3'b111) begin
              buf_ok_d = 1'b0;
            end
          end
        end
      end

      rgpq_pkg::WS_FETCH: begin
        rd_en_o = 1'b1;
        state_d = rgpq_pkg::WS_WAIT;
      end

      rgpq_pkg::WS_WAIT: begin
        byte_d   = rd_data_i;
        buf_ok_d = 1'b1;
        state_d  = rgpq_pkg::WS_FIELD;
      end

      rgpq_pkg::WS_RUN: begin
        // one zero-run plus one-run pass per cycle; the target never lies behind p
        if (18'(tgt_q) < sum_zero) begin
          res_d   = rgpq_pkg::CLS_BACKGROUND;
          state_d = rgpq_pkg::WS_DONE;
        end else if (18'(tgt_q) < sum_one) begin
          res_d   = rgpq_pkg::CLS_FOREGROUND;
          state_d = rgpq_pkg::WS_DONE;
        end else begin
          p_d = sum_one[15:0];
          // an empty record adds nothing, so its remaining passes are skipped
          if (ones_q == '0 || sum_one == 18'(p_q)) begin
            if (sum_one >= 18'(area_q)) begin
              res_d   = rgpq_pkg::CLS_TRANSPARENT;
              state_d = rgpq_pkg::WS_DONE;
            end else begin
              phase_d = rgpq_pkg::PH_ZERO;
              cnt_d   = '0;
              val_d   = '0;
              state_d = rgpq_pkg::WS_FIELD;
            end
          end else begin
            ones_d = ones_q - 1'b1;
          end
        end
      end

      rgpq_pkg::WS_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_class_d = res_q;
          case (res_q)
            rgpq_pkg::CLS_BACKGROUND: out_color_d = cfg_i.background_color;
            rgpq_pkg::CLS_FOREGROUND: out_color_d = cfg_i.foreground_color;
            default:                  out_color_d = '0;
          endcase
          state_d = rgpq_pkg::WS_IDLE;
        end
      end

      default: state_d = rgpq_pkg::WS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rgpq_pkg::WS_IDLE;
      buf_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      buf_ok_q    <= buf_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q     <= phase_d;
    res_q       <= res_d;
    pos_q       <= pos_d;
    ones_q      <= ones_d;
    cnt_q       <= cnt_d;
    val_q       <= val_d;
    nz_q        <= nz_d;
    no_q        <= no_d;
    p_q         <= p_d;
    tgt_q       <= tgt_d;
    area_q      <= area_d;
    x_q         <= x_d;
    y_q         <= y_d;
    byte_q      <= byte_d;
    out_class_q <= out_class_d;
    out_color_q <= out_color_d;
  end

  assign idle_o      = (state_q == rgpq_pkg::WS_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_class_o = out_class_q;
  assign out_color_o = out_color_q;

endmodule

/* tb/tb_rle_glyph_pixel_query.sv */
module tb_rle_glyph_pixel_query;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_BYTES    = 256;
  localparam int unsigned STORE_BITS     = STORE_BYTES * 8;
  // Quiet cycles allowed before the run is declared hung. A query that walks the
  // whole store must fit inside it, as must the long output hold-off.
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned END_CYCLES     = 64;

  typedef struct {
    rgpq_pkg::pixel_class_e cls;
    logic [31:0]            color;
    logic [7:0]             x;
    logic [7:0]             y;
  } pixel_expect_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // byte_index[7:0], byte_value[15:8], pixel_x[23:16],
                               // pixel_y[31:24]
  logic        s_axis_tuser;   // mode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // pixel_class[1:0], pixel_color[33:2], zero pad[39:34]

  // Shadow of the block: bitmap bytes and the register set as last written.
  logic [7:0]     glyph_bytes [STORE_BYTES];
  rgpq_pkg::cfg_t cur_cfg;
  pixel_expect_t  pending_pixels [$];

  int unsigned mismatch_count   = 0;
  int unsigned quiet_cycles     = 0;
  int          sink_hold_cycles = 0;
  bit          src_gaps_on      = 1'b1;
  bit          sink_stalls_on   = 1'b1;

  rle_glyph_pixel_query #(
    .BITMAP_BYTES(STORE_BYTES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pixel predictor: decode the coded stream the same way the block must.
  // ---------------------------------------------------------------------------

  function automatic bit stream_bit(input int unsigned pos);
    return glyph_bytes[pos >> 3][pos[2:0]];
  endfunction

  // Read one run-count field. Fails when the field would run off the store.
  // Fields wider than the widest count still consume their bits but read as zero.
  function automatic bit take_count(inout int unsigned pos, input int unsigned len,
                                    output longint unsigned val);
    val = 0;
    if (pos > STORE_BITS || len > STORE_BITS - pos) return 1'b0;
    if (len <= rgpq_pkg::MaxCountBits) begin
      for (int unsigned i = 0; i < len; i++) begin
        if (stream_bit(pos + i)) val[i] = 1'b1;
      end
    end
    pos += len;
    return 1'b1;
  endfunction

  // Read the unary repeat field: ones closed by a zero. Fails at the store end.
  function automatic bit take_repeat(inout int unsigned pos, output longint unsigned reps);
    longint unsigned ones;
    bit closed;
    ones   = 0;
    closed = 1'b0;
    reps   = 0;
    while (!closed && pos < STORE_BITS) begin
      if (stream_bit(pos)) begin
        ones++;
        pos++;
      end else begin
        closed = 1'b1;
      end
    end
    if (!closed) return 1'b0;
    pos++;
    reps = ones + 1;
    return 1'b1;
  endfunction

  function automatic void predict_pixel(input logic [7:0] px, input logic [7:0] py,
                                        output rgpq_pkg::pixel_class_e cls,
                                        output logic [31:0] color);
    longint unsigned target, area, covered, zeros, ones, reps;
    int unsigned pos;
    bit done;
    cls     = rgpq_pkg::CLS_TRANSPARENT;
    color   = '0;
    done    = 1'b0;
    covered = 0;
    pos     = cur_cfg.start_bit;
    target  = longint'(py) * cur_cfg.glyph_width + px;
    area    = longint'(cur_cfg.glyph_width) * cur_cfg.glyph_height;
    // Empty box or a pixel outside it: transparent without walking.
    if (cur_cfg.glyph_width == 0 || cur_cfg.glyph_height == 0 ||
        px >= cur_cfg.glyph_width || py >= cur_cfg.glyph_height) done = 1'b1;
    while (!done) begin
      if (!take_count(pos, cur_cfg.zero_run_bits, zeros)) done = 1'b1;
      else if (!take_count(pos, cur_cfg.one_run_bits, ones)) done = 1'b1;
      else if (!take_repeat(pos, reps)) done = 1'b1;
      else begin
        for (longint unsigned r = 0; r < reps && !done; r++) begin
          if (target >= covered && target < covered + zeros) begin
            cls   = rgpq_pkg::CLS_BACKGROUND;
            color = cur_cfg.background_color;
            done  = 1'b1;
          end else begin
            covered += zeros;
            if (target >= covered && target < covered + ones) begin
              cls   = rgpq_pkg::CLS_FOREGROUND;
              color = cur_cfg.foreground_color;
              done  = 1'b1;
            end else begin
              covered += ones;
            end
          end
        end
        // Box covered without reaching the pixel: stop, transparent.
        if (covered >= area) done = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one word; enter and leave at a falling edge. Valid stays high on return
  // so a following word can go out back to back; drain_results lowers it.
  task automatic send_word(input rgpq_pkg::mode_e word_mode, input logic [7:0] byte_idx,
                           input logic [7:0] byte_val, input logic [7:0] px,
                           input logic [7:0] py);
    pixel_expect_t want;
    while (src_gaps_on && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px, byte_val, byte_idx};
    s_axis_tuser  <= word_mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // Word taken at this edge: update the shadow store or queue the answer.
    if (word_mode == rgpq_pkg::MODE_WRITE) begin
      glyph_bytes[byte_idx] = byte_val;
    end else begin
      want.x = px;
      want.y = py;
      predict_pixel(px, py, want.cls, want.color);
      pending_pixels.push_back(want);
    end
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every queued answer is back and the block is quiet.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write all seven registers, with junk above each narrow field to check the masking.
  // Call only while idle, at a falling edge.
  task automatic load_config(input rgpq_pkg::cfg_t c);
    rgpq_pkg::cfg_reg_e reg_idx;
    logic [31:0]        data;
    for (int i = 0; i <= int'(rgpq_pkg::REG_BACKGROUND_COLOR); i++) begin
      reg_idx = rgpq_pkg::cfg_reg_e'(i);
      data    = $urandom();
      case (reg_idx)
        rgpq_pkg::REG_ZERO_RUN_BITS:    data[4:0] = c.zero_run_bits;
        rgpq_pkg::REG_ONE_RUN_BITS:     data[4:0] = c.one_run_bits;
        rgpq_pkg::REG_GLYPH_WIDTH:      data[7:0] = c.glyph_width;
        rgpq_pkg::REG_GLYPH_HEIGHT:     data[7:0] = c.glyph_height;
        rgpq_pkg::REG_START_BIT:        data[2:0] = c.start_bit;
        rgpq_pkg::REG_FOREGROUND_COLOR: data      = c.foreground_color;
        default:                        data      = c.background_color;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx;
      cfg_data_i <= data;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic rgpq_pkg::cfg_t random_cfg();
    rgpq_pkg::cfg_t c;
    c.zero_run_bits    = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(1, 16);
    c.one_run_bits     = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(1, 16);
    c.glyph_width      = $urandom_range(1, 20);
    c.glyph_height     = $urandom_range(1, 20);
    c.start_bit        = $urandom_range(7);
    c.foreground_color = $urandom();
    c.background_color = $urandom();
    return c;
  endfunction

  // Mostly a coordinate inside the box, sometimes anywhere in the byte range.
  function automatic logic [7:0] pick_coord(input logic [7:0] limit);
    if (limit == 0 || $urandom_range(99) < 10) return $urandom_range(255);
    return $urandom_range(limit - 1);
  endfunction

  // Writes land mostly in the head of the stream, where the walks spend their time.
  task automatic send_random_item(input int unsigned write_pct);
    if ($urandom_range(99) < write_pct)
      send_word(rgpq_pkg::MODE_WRITE,
                ($urandom_range(99) < 80) ? $urandom_range(31) : $urandom_range(255),
                $urandom_range(255), $urandom_range(255), $urandom_range(255));
    else
      send_word(rgpq_pkg::MODE_QUERY, $urandom_range(255), $urandom_range(255),
                pick_coord(cur_cfg.glyph_width), pick_coord(cur_cfg.glyph_height));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Write every byte of the store so no walk ever reads an unwritten byte, then
  // ask a few pixels under the register values left by reset.
  task automatic test_fill_store();
    for (int i = 0; i < STORE_BYTES; i++)
      send_word(rgpq_pkg::MODE_WRITE, 8'(i), $urandom_range(255), $urandom_range(255),
                $urandom_range(255));
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd0, 8'd0);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd7, 8'd7);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd3, 8'd5);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd8, 8'd8);
    drain_results();
  endtask

  task automatic test_directed_cases();
    rgpq_pkg::cfg_t c;
    // Known head of stream: zero run of 3, one run of 2, single pass.
    c = '{zero_run_bits: 5'd4, one_run_bits: 5'd4, glyph_width: 8'd8, glyph_height: 8'd8,
          start_bit: 3'd0, foreground_color: 32'h7FFF_FFFF, background_color: 32'h8000_0000};
    load_config(c);
    send_word(rgpq_pkg::MODE_WRITE, 8'd0, 8'h23, 8'h00, 8'h00);
    send_word(rgpq_pkg::MODE_WRITE, 8'd1, 8'h00, 8'hFF, 8'hFF);
    send_word(rgpq_pkg::MODE_WRITE, 8'd255, 8'hFF, 8'h00, 8'h00);
    send_word(rgpq_pkg::MODE_WRITE, 8'd128, 8'h00, 8'hFF, 8'hFF);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd0, 8'd0);
    send_word(rgpq_pkg::MODE_QUERY, 8'hFF, 8'hFF, 8'd2, 8'd0);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd3, 8'd0);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd4, 8'd0);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd7, 8'd7);
    // Outside the box on each axis and at the far corner.
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd8, 8'd0);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd0, 8'd8);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd255, 8'd255);
    drain_results();

    // Empty box: everything transparent.
    c.glyph_width = 8'd0;
    load_config(c);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd0, 8'd0);
    drain_results();
    c.glyph_width  = 8'd8;
    c.glyph_height = 8'd0;
    load_config(c);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd0, 8'd0);
    drain_results();

    // Zero-width count field, and a count field too wide to yield a value.
    c.glyph_height  = 8'd8;
    c.zero_run_bits = 5'd0;
    c.one_run_bits  = 5'd17;
    load_config(c);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd0, 8'd0);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd3, 8'd2);
    drain_results();
    c.zero_run_bits = 5'd31;
    c.one_run_bits  = 5'd0;
    load_config(c);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd1, 8'd0);
    drain_results();

    // Largest box from the last start bit: far pixels run off the store end.
    c = '{zero_run_bits: 5'd2, one_run_bits: 5'd3, glyph_width: 8'd255, glyph_height: 8'd255,
          start_bit: 3'd7, foreground_color: 32'h0000_0001, background_color: 32'hFFFF_FFFE};
    load_config(c);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd254, 8'd254);
    send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, 8'd0, 8'd0);
    drain_results();
  endtask

  task automatic test_config_extremes();
    rgpq_pkg::cfg_t c;
    c = '{zero_run_bits: 5'd1, one_run_bits: 5'd1, glyph_width: 8'd1, glyph_height: 8'd1,
          start_bit: 3'd0, foreground_color: 32'h8000_0000, background_color: 32'h7FFF_FFFF};
    load_config(c);
    repeat (40) send_random_item(40);
    drain_results();
    // Widest counts over the largest box; keep the item count low, walks are long.
    c = '{zero_run_bits: 5'd16, one_run_bits: 5'd16, glyph_width: 8'd255,
          glyph_height: 8'd255, start_bit: 3'd7, foreground_color: 32'hFFFF_FFFF,
          background_color: 32'h0000_0000};
    load_config(c);
    repeat (14) send_random_item(30);
    drain_results();
  endtask

  // Hold the result side off while queries keep coming, so the block fills up
  // and has to stall its input; then drain everything before going on.
  task automatic test_output_backpressure();
    rgpq_pkg::cfg_t c;
    c = random_cfg();
    c.glyph_width  = 8'd4;
    c.glyph_height = 8'd4;
    load_config(c);
    sink_hold_cycles = 300;
    repeat (12)
      send_word(rgpq_pkg::MODE_QUERY, 8'h00, 8'h00, $urandom_range(3), $urandom_range(3));
    drain_results();
  endtask

  // A long stretch with neither side idling.
  task automatic test_back_to_back();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    load_config(random_cfg());
    repeat (80) send_random_item(35);
    drain_results();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  task automatic test_random_glyphs(input int unsigned phases);
    for (int unsigned ph = 0; ph < phases; ph++) begin
      load_config(random_cfg());
      for (int k = 0; k < 70; k++) begin
        send_random_item(35);
        // Now and then pause the sender until every answer is back.
        if ($urandom_range(99) < 2) drain_results();
      end
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, checking and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        m_axis_tready <= !(sink_stalls_on && $urandom_range(99) < 18);
      end
    end
  end

  // Compare each result word with the oldest queued answer.
  always @(posedge clk_i) begin : check_results
    pixel_expect_t want;
    logic [1:0]    got_cls;
    logic [31:0]   got_color;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_cls   = m_axis_tdata[1:0];
      got_color = m_axis_tdata[33:2];
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result word with no query pending (class %0d)", got_cls));
      end else begin
        want = pending_pixels.pop_front();
        if (got_cls !== want.cls)
          report_mismatch($sformatf("pixel (%0d,%0d) class %0d, expected %0d",
                                    want.x, want.y, got_cls, want.cls));
        if (got_color !== want.color)
          report_mismatch($sformatf("pixel (%0d,%0d) color %h, expected %h",
                                    want.x, want.y, got_color, want.color));
      end
    end
  end

  // Count cycles in which no word moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d answers pending",
               quiet_cycles, pending_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = rgpq_pkg::REG_ZERO_RUN_BITS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = rgpq_pkg::MODE_WRITE;
    cur_cfg = '{zero_run_bits: rgpq_pkg::RstZeroRunBits,
                one_run_bits: rgpq_pkg::RstOneRunBits,
                glyph_width: rgpq_pkg::RstGlyphWidth,
                glyph_height: rgpq_pkg::RstGlyphHeight,
                start_bit: rgpq_pkg::RstStartBit,
                foreground_color: rgpq_pkg::RstColor,
                background_color: rgpq_pkg::RstColor};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_fill_store();
    test_directed_cases();
    test_config_extremes();
    test_output_backpressure();
    test_back_to_back();
    test_random_glyphs(14);

    // Let any stray result word show up before the verdict.
    drain_results();
    repeat (END_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
